// ===== hdl/cdnsr_pkg.sv =====
// Shared types, constants and the answer-record byte table for the
// captive DNS responder. No dependencies.
`default_nettype none
package cdnsr_pkg;

  localparam int unsigned BUFFER_BYTES_DEF = 320;
  localparam int unsigned ANSWER_LEN       = 16;
  localparam int unsigned HEADER_LEN       = 12;
  localparam logic [7:0]  MAX_LABEL        = 8'd63;
  localparam logic [2:0]  TAIL_LEN         = 3'd4;

  localparam logic [31:0] IPV4_RESET = 32'hC0A8_0401;
  localparam logic [31:0] TTL_RESET  = 32'd30;

  // Configuration register indexes.
  localparam logic [0:0] REG_IPV4 = 1'd0;
  localparam logic [0:0] REG_TTL  = 1'd1;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_NAME   = 2'd1,
    PH_TAIL   = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       keep;
  } out_t;

  // Result of parsing one accepted query byte.
  typedef struct packed {
    logic       echo;
    logic [7:0] echo_byte;
    logic       keep;
  } parse_res_t;

  // Byte idx of the appended A record: pointer, type, class, TTL, length, address.
  function automatic logic [7:0] answer_byte(input logic [3:0] idx,
                                             input logic [31:0] ttl,
                                             input logic [31:0] ipv4);
    logic [7:0] b;
    b = 8'h00;
    case (idx)
      4'd0:    b = 8'hC0;
      4'd1:    b = 8'h0C;
      4'd2:    b = 8'h00;
      4'd3:    b = 8'h01;
      4'd4:    b = 8'h00;
      4'd5:    b = 8'h01;
      4'd6:    b = ttl[31:24];
      4'd7:    b = ttl[23:16];
      4'd8:    b = ttl[15:8];
      4'd9:    b = ttl[7:0];
      4'd10:   b = 8'h00;
      4'd11:   b = 8'h04;
      4'd12:   b = ipv4[31:24];
      4'd13:   b = ipv4[23:16];
      4'd14:   b = ipv4[15:8];
      default: b = ipv4[7:0];
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/cdnsr_parse.sv =====
// Query byte parser: header rewrite, question-name walk and verdict.
// Depends on cdnsr_pkg.
`default_nettype none
module cdnsr_parse #(
  parameter int unsigned BUFFER_BYTES = cdnsr_pkg::BUFFER_BYTES_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   accept,
  input  wire cdnsr_pkg::in_t         in_item,
  output cdnsr_pkg::parse_res_t       res
);
  import cdnsr_pkg::*;

  localparam int unsigned PosW = $clog2(BUFFER_BYTES);
  localparam logic [PosW-1:0] Limit = PosW'(BUFFER_BYTES - ANSWER_LEN);

  logic [PosW-1:0] pos_r, pos_nxt;
  phase_t          phase_r, phase_nxt;
  logic [5:0]      label_r, label_nxt;
  logic [15:0]     qcount_r, qcount_nxt;
  logic [2:0]      tail_r, tail_nxt;
  logic            bad_r, bad_nxt;
  logic            in_buf;
  logic [7:0]      b;
  logic [2:0]      tail_dec;

  assign b      = in_item.data_byte;
  assign in_buf = (pos_r < Limit);

  always_comb begin
    pos_nxt    = pos_r;
    phase_nxt  = phase_r;
    label_nxt  = label_r;
    qcount_nxt = qcount_r;
    tail_nxt   = tail_r;
    bad_nxt    = bad_r;
    tail_dec   = (tail_r != 3'd0) ? tail_r - 3'd1 : tail_r;
    res.echo      = in_buf;
    res.echo_byte = b;
    if (pos_r == PosW'(2))      res.echo_byte = 8'h81;
    else if (pos_r == PosW'(3)) res.echo_byte = 8'h80;
    else if (pos_r == PosW'(6)) res.echo_byte = 8'h00;
    else if (pos_r == PosW'(7)) res.echo_byte = 8'h01;

    if (in_buf) begin
      pos_nxt = pos_r + PosW'(1);
      if (pos_r == PosW'(4))      qcount_nxt[15:8] = b;
      else if (pos_r == PosW'(5)) qcount_nxt[7:0]  = b;
      unique case (phase_r)
        PH_HEADER: begin
          if (pos_r == PosW'(HEADER_LEN - 1)) begin
            phase_nxt = PH_NAME;
            label_nxt = 6'd0;
          end
        end
        PH_NAME: begin
          if (!bad_r) begin
            if (label_r != 6'd0) begin
              label_nxt = label_r - 6'd1;
            end else if (b == 8'd0) begin
              phase_nxt = PH_TAIL;
              tail_nxt  = TAIL_LEN;
            end else if (b > MAX_LABEL) begin
              bad_nxt = 1'b1;
            end else begin
              label_nxt = b[5:0];
            end
          end
        end
        PH_TAIL: begin
          tail_nxt = tail_dec;
          if (tail_dec == 3'd0) phase_nxt = PH_DONE;
        end
        default: begin
        end
      endcase
    end
    res.keep = (phase_nxt == PH_DONE) && !bad_nxt && (qcount_nxt == 16'd1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      phase_r  <= PH_HEADER;
      label_r  <= 6'd0;
      qcount_r <= 16'd0;
      tail_r   <= 3'd0;
      bad_r    <= 1'b0;
    end else if (accept) begin
      if (in_item.last_byte) begin
        pos_r    <= '0;
        phase_r  <= PH_HEADER;
        label_r  <= 6'd0;
        qcount_r <= 16'd0;
        tail_r   <= 3'd0;
        bad_r    <= 1'b0;
      end else begin
        pos_r    <= pos_nxt;
        phase_r  <= phase_nxt;
        label_r  <= label_nxt;
        qcount_r <= qcount_nxt;
        tail_r   <= tail_nxt;
        bad_r    <= bad_nxt;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/captive_dns_responder_top.sv =====
// Top level of the captive DNS responder: handshakes, answer sequencer and
// configuration registers. Depends on cdnsr_pkg and cdnsr_parse.
//
//   Port group  Dir  Handshake            Beat
//   in_*        in   in_valid / in_stall  one query byte with last mark
//   out_*       out  out_valid / out_stall one reply byte with last and keep
//   cfg_*       in   cfg_valid / cfg_ready register index and 32-bit data
//
// A query byte inside the buffer limit appears on the output register in the
// cycle after it is accepted. The last byte adds sixteen answer beats from
// the answer sequencer, during which input is held off. Reset is synchronous
// and active low; it clears the parser and restores the default address and
// TTL. Outside the answer, input is taken whenever the output register is
// empty or drains in the same cycle, so output stall reaches in_stall.
`default_nettype none
module captive_dns_responder_top #(
  parameter int unsigned BUFFER_BYTES = cdnsr_pkg::BUFFER_BYTES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output      logic             in_stall,
  input  wire cdnsr_pkg::in_t   in_data,
  output      logic             out_valid,
  input  wire logic             out_stall,
  output      cdnsr_pkg::out_t  out_data,
  input  wire logic             cfg_valid,
  output      logic             cfg_ready,
  input  wire logic [0:0]       cfg_index,
  input  wire logic [31:0]      cfg_wdata
);
  import cdnsr_pkg::*;

  parse_res_t  pres;
  logic        in_accept;
  logic        out_free;
  logic        out_valid_r;
  out_t        out_data_r;
  logic        ans_active_r;
  logic [3:0]  ans_idx_r;
  logic        keep_r;
  logic [31:0] ipv4_r;
  logic [31:0] ttl_r;

  // The output register is free when empty or being taken this cycle.
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = ans_active_r || !out_free;
  assign in_accept = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  // User must rewrite registers between datagrams; answers alone hold them off.
  assign cfg_ready = !ans_active_r;

  cdnsr_parse #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_parse (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_accept),
    .in_item(in_data),
    .res    (pres)
  );

  // Output register and answer sequencer. An echo beat and an answer beat
  // never compete, since input is stalled while the answer runs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      ans_active_r <= 1'b0;
      ans_idx_r    <= 4'd0;
      keep_r       <= 1'b0;
    end else begin
      if (in_accept && pres.echo) begin
        out_valid_r         <= 1'b1;
        out_data_r.out_byte <= pres.echo_byte;
        out_data_r.out_last <= 1'b0;
        out_data_r.keep     <= 1'b0;
      end else if (ans_active_r && out_free) begin
        out_valid_r         <= 1'b1;
        out_data_r.out_byte <= answer_byte(ans_idx_r, ttl_r, ipv4_r);
        out_data_r.out_last <= (ans_idx_r == 4'(ANSWER_LEN - 1));
        out_data_r.keep     <= (ans_idx_r == 4'(ANSWER_LEN - 1)) && keep_r;
        ans_idx_r           <= ans_idx_r + 4'd1;
        if (ans_idx_r == 4'(ANSWER_LEN - 1)) ans_active_r <= 1'b0;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (in_accept && in_data.last_byte) begin
        ans_active_r <= 1'b1;
        ans_idx_r    <= 4'd0;
        keep_r       <= pres.keep;
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ipv4_r <= IPV4_RESET;
      ttl_r  <= TTL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IPV4: ipv4_r <= cfg_wdata;
        REG_TTL:  ttl_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // While the answer runs, no query byte may enter.
  a_stall_in_answer: assert property (@(posedge clk) disable iff (!rst_n)
    ans_active_r |-> in_stall)
    else $error("query byte accepted during answer");

  // The final beat is loaded together with the end of the answer.
  a_last_ends_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.out_last) |-> !ans_active_r)
    else $error("answer still running after final beat");

  // Keep is only ever raised on the final beat.
  a_keep_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.keep) |-> out_data_r.out_last)
    else $error("keep set on a non-final beat");

  // The answer index rests at zero between answers.
  a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !ans_active_r |-> (ans_idx_r == 4'd0))
    else $error("answer index not at rest");

endmodule
`default_nettype wire
